[hw/rtl/lfs_pkg.sv]
package lfs_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int SAMPLE_W    = 12;
   localparam int NUM_SAMPLES = 12;
   localparam int IN_DATA_W   = SAMPLE_W * NUM_SAMPLES;
   localparam int OUT_DATA_W  = 72;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

   localparam int DEN_W = 15;
   localparam logic [DEN_W-1:0] DEN_OFFSET = DEN_W'(1 << SAMPLE_BITS);

   localparam int QUO_W     = 15;
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = 4;
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

   localparam int MUL_A_W = 19;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 1;

   localparam logic [MUL_B_W-1:0] LOST_RECIP = MUL_B_W'(13107);

   localparam logic [1:0] DIR_FRONT = 2'd0;
   localparam logic [1:0] DIR_BACK  = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   localparam int ADDR_W = 5;
   localparam logic [2:0] REG_TRAVEL_DIRECTION = 3'd0;
   localparam logic [2:0] REG_DRIVE_SPEED      = 3'd1;
   localparam logic [2:0] REG_LOST_THRESHOLD   = 3'd2;
   localparam logic [2:0] REG_GAIN_LONG_AXIS   = 3'd3;
   localparam logic [2:0] REG_GAIN_SIDE_AXIS   = 3'd4;
   localparam logic [2:0] REG_GAIN_DERIVATIVE  = 3'd5;

   localparam logic [1:0]  RST_TRAVEL_DIRECTION = 2'd0;
   localparam logic [15:0] RST_DRIVE_SPEED      = 16'd4096;
   localparam logic [11:0] RST_LOST_THRESHOLD   = 12'd1000;
   localparam logic [15:0] RST_GAIN_LONG_AXIS   = 16'd26214;
   localparam logic [15:0] RST_GAIN_SIDE_AXIS   = 16'd9830;
   localparam logic [15:0] RST_GAIN_DERIVATIVE  = 16'd0;

   typedef struct packed {
      logic [1:0]  travel_direction;
      logic [15:0] drive_speed;
      logic [11:0] lost_threshold;
      logic [15:0] gain_long_axis;
      logic [15:0] gain_side_axis;
      logic [15:0] gain_derivative;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic mul_p;
      logic mul_d;
      logic sum;
      logic lost_mul;
      logic write_out;
   } cmd_type;

   typedef struct packed {
      logic lost_now;
   } sts_type;

endpackage

[hw/rtl/line_follow_steering.sv]
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tdata: sample_0..sample_11
// rsp_      out  rsp_tvalid/rsp_tready  tdata: vel_x, vel_y, turn_rate, line_error
//                                       tuser: line_gone
// csr_      in   APB, pready high       six registers at 4*index
//
// Frame with line seen: accept, 15 restoring divide steps, two multiplies
// on the one shared multiplier, sum, output load.
// Frame with line lost: accept, reciprocal multiply, output load.
// Next frame is taken once the current result is in the output register.
// A stalled result holds; reset clears control state and the stored error.
module line_follow_steering (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lfs_pkg::IN_DATA_W-1:0]  req_tdata,   // sample_0 .. sample_11, 12 bits each
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lfs_pkg::OUT_DATA_W-1:0] rsp_tdata,   // vel_x, vel_y, turn_rate, line_error, 0
   output logic                           rsp_tuser,   // line_gone
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lfs_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   lfs_pkg::cfg_type cfg;
   lfs_pkg::cmd_type cmd;
   lfs_pkg::sts_type sts;

   lfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lfs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

[hw/rtl/lfs_csr.sv]
module lfs_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [lfs_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output lfs_pkg::cfg_type           cfg
);

   lfs_pkg::cfg_type cfg_ff;
   lfs_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [2:0]       idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            lfs_pkg::REG_TRAVEL_DIRECTION: cfg_in.travel_direction = csr_pwdata[1:0];
            lfs_pkg::REG_DRIVE_SPEED:      cfg_in.drive_speed      = csr_pwdata[15:0];
            lfs_pkg::REG_LOST_THRESHOLD:   cfg_in.lost_threshold   = csr_pwdata[11:0];
            lfs_pkg::REG_GAIN_LONG_AXIS:   cfg_in.gain_long_axis   = csr_pwdata[15:0];
            lfs_pkg::REG_GAIN_SIDE_AXIS:   cfg_in.gain_side_axis   = csr_pwdata[15:0];
            lfs_pkg::REG_GAIN_DERIVATIVE:  cfg_in.gain_derivative  = csr_pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         lfs_pkg::REG_TRAVEL_DIRECTION: csr_prdata = {30'b0, cfg_ff.travel_direction};
         lfs_pkg::REG_DRIVE_SPEED:      csr_prdata = {16'b0, cfg_ff.drive_speed};
         lfs_pkg::REG_LOST_THRESHOLD:   csr_prdata = {20'b0, cfg_ff.lost_threshold};
         lfs_pkg::REG_GAIN_LONG_AXIS:   csr_prdata = {16'b0, cfg_ff.gain_long_axis};
         lfs_pkg::REG_GAIN_SIDE_AXIS:   csr_prdata = {16'b0, cfg_ff.gain_side_axis};
         lfs_pkg::REG_GAIN_DERIVATIVE:  csr_prdata = {16'b0, cfg_ff.gain_derivative};
         default: csr_prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.travel_direction <= lfs_pkg::RST_TRAVEL_DIRECTION;
         cfg_ff.drive_speed      <= lfs_pkg::RST_DRIVE_SPEED;
         cfg_ff.lost_threshold   <= lfs_pkg::RST_LOST_THRESHOLD;
         cfg_ff.gain_long_axis   <= lfs_pkg::RST_GAIN_LONG_AXIS;
         cfg_ff.gain_side_axis   <= lfs_pkg::RST_GAIN_SIDE_AXIS;
         cfg_ff.gain_derivative  <= lfs_pkg::RST_GAIN_DERIVATIVE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/lfs_ctrl.sv]
module lfs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  lfs_pkg::sts_type sts,
   output lfs_pkg::cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIV  = 7'b0000010,
      ST_MULP = 7'b0000100,
      ST_MULD = 7'b0001000,
      ST_SUM  = 7'b0010000,
      ST_LMUL = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   logic [lfs_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                     valid_ff, valid_in;
   logic                     req_fire;
   logic                     out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~valid_ff | rsp_tready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = sts.lost_now ? ST_LMUL : ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == lfs_pkg::DIV_LAST) begin
               state_in = ST_MULP;
            end
         end
         ST_MULP: begin
            cmd.mul_p = 1'b1;
            state_in  = ST_MULD;
         end
         ST_MULD: begin
            cmd.mul_d = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_DONE;
         end
         ST_LMUL: begin
            cmd.lost_mul = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.write_out = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.write_out) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

[hw/rtl/lfs_dpath.sv]
module lfs_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  lfs_pkg::cfg_type               cfg,
   input  lfs_pkg::cmd_type               cmd,
   output lfs_pkg::sts_type               sts,
   input  logic [lfs_pkg::IN_DATA_W-1:0]  req_tdata,
   output logic [lfs_pkg::OUT_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser
);

   logic [lfs_pkg::SAMPLE_W-1:0] samp [lfs_pkg::NUM_SAMPLES];
   logic [lfs_pkg::SAMPLE_W-1:0] sa, sb, sc, sd;
   logic                         lost_c;
   logic [lfs_pkg::DEN_W-1:0]    pos_c, neg_c, mag_c, den_c;
   logic                         negative_c;

   logic                         lost_ff;
   logic                         neg_ff;
   logic [lfs_pkg::DEN_W-1:0]    den_ff;
   logic [lfs_pkg::DEN_W-1:0]    rem_ff, rem_in;
   logic [lfs_pkg::QUO_W-1:0]    quo_ff, quo_in;
   logic [lfs_pkg::DEN_W:0]      trial;
   logic                         ge;

   logic signed [15:0]           err_c, err_ff, prev_ff;
   logic signed [16:0]           change_c;
   logic [15:0]                  gain;
   logic [17:0]                  x3;

   logic signed [lfs_pkg::MUL_A_W-1:0] mul_a;
   logic signed [lfs_pkg::MUL_B_W-1:0] mul_b;
   logic signed [lfs_pkg::PROD_W-1:0]  prod, p1_ff, p2_ff;
   logic signed [lfs_pkg::ACC_W-1:0]   acc_ff, acc_adj, tq;
   logic signed [15:0]                 turn_c;

   logic [15:0]                  q0;
   logic [17:0]                  r5;
   logic [15:0]                  spd_lost, spd;
   logic signed [16:0]           spd_s, vel_x, vel_y;
   logic signed [15:0]           line_err;

   logic [lfs_pkg::OUT_DATA_W-1:0] tdata_ff;
   logic                           tuser_ff;

   always_comb begin
      for (int i = 0; i < lfs_pkg::NUM_SAMPLES; i++) begin
         samp[i] = req_tdata[lfs_pkg::SAMPLE_W*i +: lfs_pkg::SAMPLE_W] & lfs_pkg::SAMPLE_MASK;
      end
   end

   always_comb begin
      unique case (cfg.travel_direction)
         lfs_pkg::DIR_FRONT: begin
            sa = samp[0]; sb = samp[1]; sc = samp[2];  sd = samp[3];
         end
         lfs_pkg::DIR_BACK: begin
            sa = samp[0]; sb = samp[1]; sc = samp[3];  sd = samp[4];
         end
         lfs_pkg::DIR_RIGHT: begin
            sa = samp[8]; sb = samp[9]; sc = samp[10]; sd = samp[11];
         end
         default: begin
            sa = samp[4]; sb = samp[5]; sc = samp[6];  sd = samp[7];
         end
      endcase
   end

   assign lost_c = (sa < cfg.lost_threshold) && (sb < cfg.lost_threshold) &&
                   (sc < cfg.lost_threshold) && (sd < cfg.lost_threshold);
   assign sts.lost_now = lost_c;

   assign pos_c      = {3'b0, sc} + {2'b0, sd, 1'b0} + {3'b0, sd};
   assign neg_c      = {3'b0, sb} + {2'b0, sa, 1'b0} + {3'b0, sa};
   assign negative_c = (neg_c > pos_c);
   assign mag_c      = negative_c ? (neg_c - pos_c) : (pos_c - neg_c);
   assign den_c      = {3'b0, sa} + {3'b0, sb} + {3'b0, sc} + {3'b0, sd} + lfs_pkg::DEN_OFFSET;

   assign trial = {rem_ff, quo_ff[lfs_pkg::QUO_W-1]};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.load) begin
         rem_in = {2'b0, mag_c[14:2]};
         quo_in = {mag_c[1:0], 13'b0};
      end else if (cmd.div_step) begin
         rem_in = ge ? lfs_pkg::DEN_W'(trial - {1'b0, den_ff}) : lfs_pkg::DEN_W'(trial);
         quo_in = {quo_ff[lfs_pkg::QUO_W-2:0], ge};
      end
   end

   assign err_c    = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign change_c = {err_ff[15], err_ff} - {prev_ff[15], prev_ff};
   assign gain     = (cfg.travel_direction == lfs_pkg::DIR_FRONT ||
                      cfg.travel_direction == lfs_pkg::DIR_BACK) ?
                     cfg.gain_long_axis : cfg.gain_side_axis;
   assign x3       = {2'b0, cfg.drive_speed} + {1'b0, cfg.drive_speed, 1'b0};

   always_comb begin
      priority if (cmd.mul_p) begin
         mul_a = {{3{err_c[15]}}, err_c};
         mul_b = {1'b0, gain};
      end else if (cmd.mul_d) begin
         mul_a = {{2{change_c[16]}}, change_c};
         mul_b = {1'b0, cfg.gain_derivative};
      end else begin
         mul_a = {1'b0, x3};
         mul_b = lfs_pkg::LOST_RECIP;
      end
   end

   assign prod = mul_a * mul_b;

   assign acc_adj = acc_ff[lfs_pkg::ACC_W-1] ? (acc_ff + lfs_pkg::ACC_W'(65535)) : acc_ff;
   assign tq      = acc_adj >>> 16;

   always_comb begin
      priority if (tq > $signed(lfs_pkg::ACC_W'(32767))) begin
         turn_c = 16'sh7fff;
      end else if (tq < -$signed(lfs_pkg::ACC_W'(32768))) begin
         turn_c = -16'sh8000;
      end else begin
         turn_c = tq[15:0];
      end
   end

   assign q0       = p1_ff[31:16];
   assign r5       = x3 - ({q0, 2'b0} + {2'b0, q0});
   assign spd_lost = q0 + {15'b0, (r5 >= 18'd5)};
   assign spd      = lost_ff ? spd_lost : cfg.drive_speed;
   assign spd_s    = $signed({1'b0, spd});
   assign line_err = lost_ff ? prev_ff : err_ff;

   always_comb begin
      vel_x = '0;
      vel_y = '0;
      unique case (cfg.travel_direction)
         lfs_pkg::DIR_FRONT: vel_y = spd_s;
         lfs_pkg::DIR_BACK:  vel_y = -spd_s;
         lfs_pkg::DIR_RIGHT: vel_x = spd_s;
         default:            vel_x = -spd_s;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lost_ff <= lost_c;
         neg_ff  <= negative_c;
         den_ff  <= den_c;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.mul_p) begin
         err_ff <= err_c;
      end
      if (cmd.mul_p | cmd.lost_mul) begin
         p1_ff <= prod;
      end
      if (cmd.mul_d) begin
         p2_ff <= prod;
      end
      if (cmd.sum) begin
         acc_ff <= {p1_ff[lfs_pkg::PROD_W-1], p1_ff} + {p2_ff[lfs_pkg::PROD_W-1], p2_ff};
      end
      if (cmd.write_out) begin
         tdata_ff <= {6'b0, line_err, (lost_ff ? 16'sd0 : turn_c), vel_y, vel_x};
         tuser_ff <= lost_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (cmd.write_out && !lost_ff) begin
         prev_ff <= err_ff;
      end
   end

   assign rsp_tdata = tdata_ff;
   assign rsp_tuser = tuser_ff;

endmodule

[verif/line_follow_steering_tb.sv]
`timescale 1ns / 100ps

module line_follow_steering_tb;

   typedef logic [lfs_pkg::NUM_SAMPLES-1:0][lfs_pkg::SAMPLE_W-1:0] frame_type;

   typedef struct {
      logic [16:0] vel_x;
      logic [16:0] vel_y;
      logic [15:0] turn_rate;
      logic        line_gone;
      logic [15:0] line_error;
   } steer_cmd_type;

   logic                           clock;
   logic                           reset       = 1'b1;
   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   logic [lfs_pkg::IN_DATA_W-1:0]  req_tdata   = '0;  // sample_0 .. sample_11, 12 bits each
   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b1;
   logic [lfs_pkg::OUT_DATA_W-1:0] rsp_tdata;  // vel_x, vel_y, turn_rate, line_error, zero pad
   logic                           rsp_tuser;  // line_gone
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [lfs_pkg::ADDR_W-1:0]     csr_paddr   = '0;
   logic [31:0]                    csr_pwdata  = '0;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   lfs_pkg::cfg_type   shadow_cfg;
   logic signed [15:0] model_prev_error;
   steer_cmd_type      pending_commands[$];
   int                 mismatch_count  = 0;
   int                 hold_off_cycles = 0;
   bit                 req_idle_on     = 1'b1;
   bit                 rsp_idle_on     = 1'b1;

   logic [1:0] dir_order[4] = '{lfs_pkg::DIR_FRONT, lfs_pkg::DIR_BACK,
                                lfs_pkg::DIR_RIGHT, lfs_pkg::DIR_LEFT};

   line_follow_steering u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic steer_cmd_type predict_steering(input frame_type frame);
      steer_cmd_type                cmd;
      logic [lfs_pkg::SAMPLE_W-1:0] sel [4];
      longint                       num, den, err, acc, turn, speed, gain;
      bit                           lost;
      case (shadow_cfg.travel_direction)
         lfs_pkg::DIR_FRONT: sel = '{frame[0], frame[1], frame[2], frame[3]};
         lfs_pkg::DIR_BACK:  sel = '{frame[0], frame[1], frame[3], frame[4]};
         lfs_pkg::DIR_RIGHT: sel = '{frame[8], frame[9], frame[10], frame[11]};
         default:            sel = '{frame[4], frame[5], frame[6], frame[7]};
      endcase
      lost = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (sel[i] >= shadow_cfg.lost_threshold) lost = 1'b0;
      end
      if (lost) begin
         speed = longint'(shadow_cfg.drive_speed) * 3 / 5;
         err   = model_prev_error;
         turn  = 0;
      end else begin
         num  = 3 * longint'(sel[3]) + longint'(sel[2]) - longint'(sel[1])
                - 3 * longint'(sel[0]);
         den  = longint'(sel[0]) + longint'(sel[1]) + longint'(sel[2]) + longint'(sel[3])
                + (longint'(1) << lfs_pkg::SAMPLE_BITS);
         err  = num * 8192 / den;
         gain = (shadow_cfg.travel_direction == lfs_pkg::DIR_FRONT ||
                 shadow_cfg.travel_direction == lfs_pkg::DIR_BACK) ?
                longint'(shadow_cfg.gain_long_axis) : longint'(shadow_cfg.gain_side_axis);
         acc  = err * gain + (err - longint'(model_prev_error))
                * longint'(shadow_cfg.gain_derivative);
         turn = acc / 65536;
         if (turn > 32767) turn = 32767;
         if (turn < -32768) turn = -32768;
         model_prev_error = 16'(err);
         speed = longint'(shadow_cfg.drive_speed);
      end
      cmd.vel_x = '0;
      cmd.vel_y = '0;
      case (shadow_cfg.travel_direction)
         lfs_pkg::DIR_FRONT: cmd.vel_y = 17'(speed);
         lfs_pkg::DIR_BACK:  cmd.vel_y = 17'(-speed);
         lfs_pkg::DIR_RIGHT: cmd.vel_x = 17'(speed);
         default:            cmd.vel_x = 17'(-speed);
      endcase
      cmd.turn_rate  = 16'(turn);
      cmd.line_gone  = lost;
      cmd.line_error = 16'(err);
      return cmd;
   endfunction

   function automatic frame_type place_line(input logic [11:0] a, b, c, d);
      frame_type frame;
      for (int i = 0; i < lfs_pkg::NUM_SAMPLES; i++) frame[i] = 12'($urandom);
      case (shadow_cfg.travel_direction)
         lfs_pkg::DIR_FRONT: begin
            frame[0] = a; frame[1] = b; frame[2] = c; frame[3] = d;
         end
         lfs_pkg::DIR_BACK: begin
            frame[0] = a; frame[1] = b; frame[3] = c; frame[4] = d;
         end
         lfs_pkg::DIR_RIGHT: begin
            frame[8] = a; frame[9] = b; frame[10] = c; frame[11] = d;
         end
         default: begin
            frame[4] = a; frame[5] = b; frame[6] = c; frame[7] = d;
         end
      endcase
      return frame;
   endfunction

   function automatic frame_type random_frame();
      logic [11:0] v [4];
      int          mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++) begin
         case (mode)
            0, 1: v[i] = (shadow_cfg.lost_threshold == 0) ? 12'($urandom) :
                         12'($urandom_range(0, shadow_cfg.lost_threshold - 1));
            2:    v[i] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            3:    v[i] = 12'(shadow_cfg.lost_threshold + $urandom_range(0, 4) - 2);
            default: v[i] = 12'($urandom);
         endcase
      end
      return place_line(v[0], v[1], v[2], v[3]);
   endfunction

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         lfs_pkg::REG_TRAVEL_DIRECTION: shadow_cfg.travel_direction = value[1:0];
         lfs_pkg::REG_DRIVE_SPEED:      shadow_cfg.drive_speed      = value[15:0];
         lfs_pkg::REG_LOST_THRESHOLD:   shadow_cfg.lost_threshold   = value[11:0];
         lfs_pkg::REG_GAIN_LONG_AXIS:   shadow_cfg.gain_long_axis   = value[15:0];
         lfs_pkg::REG_GAIN_SIDE_AXIS:   shadow_cfg.gain_side_axis   = value[15:0];
         lfs_pkg::REG_GAIN_DERIVATIVE:  shadow_cfg.gain_derivative  = value[15:0];
         default: ;
      endcase
   endtask

   // upper bits are junk on purpose, the block keeps only the register width
   task automatic apply_config(input logic [1:0] dir, input logic [15:0] speed,
                               input logic [11:0] thr, input logic [15:0] g_long,
                               input logic [15:0] g_side, input logic [15:0] g_der);
      csr_write(lfs_pkg::REG_TRAVEL_DIRECTION, {30'($urandom), dir});
      csr_write(lfs_pkg::REG_DRIVE_SPEED,      {16'($urandom), speed});
      csr_write(lfs_pkg::REG_LOST_THRESHOLD,   {20'($urandom), thr});
      csr_write(lfs_pkg::REG_GAIN_LONG_AXIS,   {16'($urandom), g_long});
      csr_write(lfs_pkg::REG_GAIN_SIDE_AXIS,   {16'($urandom), g_side});
      csr_write(lfs_pkg::REG_GAIN_DERIVATIVE,  {16'($urandom), g_der});
   endtask

   task automatic send_frame(input frame_type frame);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= frame;
      do @(posedge clock); while (!req_tready);
      pending_commands.push_back(predict_steering(frame));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic compare_field(input string label, input logic [16:0] want_v,
                                input logic [16:0] got_v);
      if (want_v !== got_v) begin
         mismatch_count++;
         $display("%t %s mismatch: expected %h actual %h", $time, label, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      steer_cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_commands.size() == 0) begin
            mismatch_count++;
            $display("%t unexpected beat: expected none actual tdata=%h tuser=%b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = pending_commands.pop_front();
            compare_field("vel_x",      want.vel_x,      rsp_tdata[16:0]);
            compare_field("vel_y",      want.vel_y,      rsp_tdata[33:17]);
            compare_field("turn_rate",  want.turn_rate,  rsp_tdata[49:34]);
            compare_field("line_error", want.line_error, rsp_tdata[65:50]);
            compare_field("pad",        '0,              rsp_tdata[71:66]);
            compare_field("line_gone",  want.line_gone,  rsp_tuser);
         end
      end
   end

   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic test_reset_values();
      send_frame(place_line(12'd0, 12'd0, 12'd0, 12'd0));
      send_frame(place_line(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
      send_frame(place_line(12'd0, 12'd0, 12'd0, 12'hFFF));
      send_frame(place_line(12'hFFF, 12'd0, 12'd0, 12'd0));
      send_frame(place_line(12'd999, 12'd0, 12'd0, 12'd0));
      send_frame(place_line(12'd0, 12'd0, 12'd1000, 12'd0));
      drain_results();
   endtask

   // full right then full left with maximum derivative gain drives the turn into saturation
   task automatic test_direction_extremes();
      foreach (dir_order[i]) begin
         apply_config(dir_order[i], 16'hFFFF, 12'd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         send_frame(place_line(12'd0, 12'd0, 12'd0, 12'hFFF));
         send_frame(place_line(12'hFFF, 12'd0, 12'd0, 12'd0));
         send_frame(place_line(12'd0, 12'd0, 12'd0, 12'hFFF));
         drain_results();
      end
      apply_config(lfs_pkg::DIR_FRONT, 16'd0, 12'd0, 16'd0, 16'd0, 16'd0);
      send_frame(place_line(12'd0, 12'd0, 12'd0, 12'd0));
      drain_results();
      apply_config(lfs_pkg::DIR_LEFT, 16'd12345, 12'hFFF, 16'd40000, 16'd20000, 16'd30000);
      send_frame(place_line(12'hFFE, 12'hFFE, 12'hFFE, 12'hFFE));
      send_frame(place_line(12'hFFE, 12'hFFE, 12'hFFF, 12'hFFE));
      drain_results();
   endtask

   task automatic test_backpressure();
      apply_config(lfs_pkg::DIR_BACK, 16'($urandom), 12'd800, 16'($urandom), 16'($urandom),
                   16'($urandom));
      req_idle_on = 1'b0;
      hold_off_cycles = 300;
      repeat (12) send_frame(random_frame());
      req_idle_on = 1'b1;
      drain_results();
   endtask

   task automatic test_sender_pause();
      apply_config(lfs_pkg::DIR_RIGHT, 16'($urandom), 12'd1500, 16'($urandom), 16'($urandom),
                   16'($urandom));
      repeat (15) send_frame(random_frame());
      req_tvalid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (15) send_frame(random_frame());
      drain_results();
   endtask

   task automatic test_random_sweep();
      for (int phase = 0; phase < 12; phase++) begin
         if (phase == 0)
            apply_config(lfs_pkg::DIR_FRONT, 16'hFFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         else if (phase == 1)
            apply_config(lfs_pkg::DIR_BACK, 16'd0, 12'd0, 16'd0, 16'd0, 16'd0);
         else
            apply_config(dir_order[phase % 4], 16'($urandom),
                         12'($urandom_range(200, 2500)), 16'($urandom),
                         16'($urandom), 16'($urandom));
         repeat (100) send_frame(random_frame());
         drain_results();
      end
   endtask

   task automatic test_quiet_tail();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      apply_config(dir_order[$urandom_range(0, 3)], 16'($urandom),
                   12'($urandom_range(200, 2500)), 16'($urandom), 16'($urandom),
                   16'($urandom));
      repeat (90) send_frame(random_frame());
      drain_results();
   endtask

   initial begin
      shadow_cfg.travel_direction = lfs_pkg::RST_TRAVEL_DIRECTION;
      shadow_cfg.drive_speed      = lfs_pkg::RST_DRIVE_SPEED;
      shadow_cfg.lost_threshold   = lfs_pkg::RST_LOST_THRESHOLD;
      shadow_cfg.gain_long_axis   = lfs_pkg::RST_GAIN_LONG_AXIS;
      shadow_cfg.gain_side_axis   = lfs_pkg::RST_GAIN_SIDE_AXIS;
      shadow_cfg.gain_derivative  = lfs_pkg::RST_GAIN_DERIVATIVE;
      model_prev_error = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_direction_extremes();
      test_backpressure();
      test_sender_pause();
      test_random_sweep();
      test_quiet_tail();
      if (mismatch_count == 0 && pending_commands.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[files.f]
hw/rtl/lfs_pkg.sv
hw/rtl/lfs_csr.sv
hw/rtl/lfs_ctrl.sv
hw/rtl/lfs_dpath.sv
hw/rtl/line_follow_steering.sv
verif/line_follow_steering_tb.sv
